// ===== hdl/pbrd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pbrd_pkg;

   localparam int BYTE_W          = 8;
   localparam int PIXEL_W         = 16;
   localparam int COL_W           = 10;
   localparam int ROW_W           = 10;
   localparam int CSR_W           = 11;
   localparam int CSR_INDEX_W     = 1;
   localparam int RUN_PIX_W       = 6;
   localparam int BYTES_PER_PIXEL = 3;
   localparam int MAX_RUN_PIXELS  = 43;

   localparam logic [CSR_INDEX_W-1:0] CFG_ROW_PIXELS = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CFG_FRAME_ROWS = 1'b1;

   localparam logic [CSR_W-1:0] ROW_PIXELS_RESET = 11'd320;
   localparam logic [CSR_W-1:0] FRAME_ROWS_RESET = 11'd240;

   // a repeat header n gives 1-n copies, i.e. 257-n for the unsigned byte
   localparam logic [BYTE_W:0] REPEAT_LEN_BASE = 9'd257;

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_LITERAL,
      PH_REPEAT
   } phase_type;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_REPEAT
   } ctrl_state_type;

   typedef struct packed {
      logic take;
      logic step;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
      logic repeat_next;
      logic run_last;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== hdl/pbrd_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pbrd_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire pbrd_pkg::dp_status_type status,
   output pbrd_pkg::dp_cmd_type        cmd
);

   pbrd_pkg::ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pbrd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pbrd_pkg::ST_IDLE: begin
            if (req_valid && status.out_free && status.repeat_next) begin
               state_in = pbrd_pkg::ST_REPEAT;
            end
         end
         pbrd_pkg::ST_REPEAT: begin
            if (status.out_free && status.run_last) begin
               state_in = pbrd_pkg::ST_IDLE;
            end
         end
      endcase
   end

   always_comb begin
      cmd.take  = (state_ff == pbrd_pkg::ST_IDLE) && req_valid && status.out_free;
      cmd.step  = (state_ff == pbrd_pkg::ST_REPEAT) && status.out_free;
      req_stall = !((state_ff == pbrd_pkg::ST_IDLE) && status.out_free);
   end

endmodule

`default_nettype wire

// ===== hdl/pbrd_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pbrd_datapath #(
   parameter int MAX_ROW_PIXELS = 1024,
   parameter int MAX_FRAME_ROWS = 1024
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire pbrd_pkg::dp_cmd_type                  cmd,
   output pbrd_pkg::dp_status_type                    status,
   input  wire logic [$clog2(MAX_ROW_PIXELS+1)-1:0]   row_pixels,
   input  wire logic [$clog2(MAX_FRAME_ROWS+1)-1:0]   frame_rows,
   input  wire logic [pbrd_pkg::BYTE_W-1:0]           req_stream_byte,
   input  wire logic                                  req_frame_start,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic [pbrd_pkg::PIXEL_W-1:0]               rsp_pixel,
   output logic [pbrd_pkg::COL_W-1:0]                 rsp_column,
   output logic [pbrd_pkg::ROW_W-1:0]                 rsp_row_index,
   output logic                                       rsp_row_end,
   output logic                                       rsp_frame_end,
   output logic                                       rsp_last_of_run
);

   localparam int EW = $clog2(MAX_ROW_PIXELS + 1);
   localparam int FW = $clog2(MAX_FRAME_ROWS + 1);
   localparam int CW = $clog2(MAX_ROW_PIXELS);
   localparam int RW = $clog2(MAX_FRAME_ROWS);
   localparam int BW = $clog2(pbrd_pkg::BYTES_PER_PIXEL * MAX_ROW_PIXELS + 1);
   localparam int BYW = pbrd_pkg::BYTE_W;

   pbrd_pkg::phase_type               phase_ff, phase_in;
   logic [BYW-1:0]                    bytes_left_ff, bytes_left_in;
   logic [2*BYW-1:0]                  held_ff, held_in;
   logic [1:0]                        comp_ff, comp_in;
   logic [BW-1:0]                     byte_col_ff, byte_col_in;
   logic [CW-1:0]                     pix_col_ff, pix_col_in;
   logic [RW-1:0]                     row_ff, row_in;
   logic [BYW-1:0]                    run_byte_ff, run_byte_in;
   logic [BYW-1:0]                    run_count_ff, run_count_in;
   logic [pbrd_pkg::RUN_PIX_W-1:0]    run_pix_ff, run_pix_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [pbrd_pkg::PIXEL_W-1:0]      rsp_pixel_ff, rsp_pixel_in;
   logic [pbrd_pkg::COL_W-1:0]        rsp_column_ff, rsp_column_in;
   logic [pbrd_pkg::ROW_W-1:0]        rsp_row_index_ff, rsp_row_index_in;
   logic                              rsp_row_end_ff, rsp_row_end_in;
   logic                              rsp_frame_end_ff, rsp_frame_end_in;
   logic                              rsp_last_ff, rsp_last_in;

   logic [BYW-1:0]                    data_byte;
   logic [BW-1:0]                     row_bytes;
   logic                              out_free;
   logic                              data_go;
   logic                              literal_go;
   logic                              emit;
   logic                              run_last;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign data_byte = cmd.step ? run_byte_ff : req_stream_byte;
   assign row_bytes = BW'(row_pixels) * BW'(pbrd_pkg::BYTES_PER_PIXEL);

   // a run step is its last when its byte is the final copy, or when it completes a
   // pixel after which the row or the pixel cap leaves nothing more to give
   assign run_last = (run_count_ff <= BYW'(1))
      || ((comp_ff == 2'd2) && (byte_col_ff < row_bytes)
         && ((byte_col_ff + BW'(1) >= row_bytes)
            || (EW'(pix_col_ff) + EW'(1) >= row_pixels)
            || (run_pix_ff == pbrd_pkg::RUN_PIX_W'(pbrd_pkg::MAX_RUN_PIXELS - 1))));

   always_comb begin
      phase_in         = phase_ff;
      bytes_left_in    = bytes_left_ff;
      held_in          = held_ff;
      comp_in          = comp_ff;
      byte_col_in      = byte_col_ff;
      pix_col_in       = pix_col_ff;
      row_in           = row_ff;
      run_byte_in      = run_byte_ff;
      run_count_in     = run_count_ff;
      run_pix_in       = run_pix_ff;
      rsp_pixel_in     = rsp_pixel_ff;
      rsp_column_in    = rsp_column_ff;
      rsp_row_index_in = rsp_row_index_ff;
      rsp_row_end_in   = 1'b0;
      rsp_frame_end_in = 1'b0;
      rsp_last_in      = 1'b0;
      data_go          = 1'b0;
      literal_go       = 1'b0;
      emit             = 1'b0;

      if (cmd.take && req_frame_start) begin
         phase_in      = pbrd_pkg::PH_HEADER;
         bytes_left_in = '0;
         held_in       = '0;
         comp_in       = '0;
         byte_col_in   = '0;
         pix_col_in    = '0;
         row_in        = '0;
      end

      if (cmd.take) begin
         unique case (phase_in)
            pbrd_pkg::PH_HEADER: begin
               // close a row that ran out or was cut short by a smaller row size
               if ((byte_col_in >= row_bytes) || (EW'(pix_col_in) >= row_pixels)) begin
                  if (pix_col_in != '0) begin
                     if (FW'(row_in) + FW'(1) >= frame_rows) begin
                        row_in = '0;
                     end else begin
                        row_in = row_in + RW'(1);
                     end
                  end
                  byte_col_in = '0;
                  pix_col_in  = '0;
                  comp_in     = '0;
                  held_in     = '0;
               end
               if (!data_byte[BYW-1]) begin
                  phase_in      = pbrd_pkg::PH_LITERAL;
                  bytes_left_in = data_byte + BYW'(1);
               end else begin
                  phase_in      = pbrd_pkg::PH_REPEAT;
                  bytes_left_in = BYW'(pbrd_pkg::REPEAT_LEN_BASE - {1'b0, data_byte});
               end
            end
            pbrd_pkg::PH_LITERAL: begin
               data_go    = 1'b1;
               literal_go = 1'b1;
            end
            default: begin
               run_byte_in  = data_byte;
               run_count_in = bytes_left_in;
               run_pix_in   = '0;
            end
         endcase
      end

      if (cmd.step) begin
         data_go = 1'b1;
      end

      // one data byte into the current pixel
      if (data_go && (byte_col_in < row_bytes)) begin
         byte_col_in = byte_col_in + BW'(1);
         unique case (comp_in)
            2'd0: begin
               held_in[2*BYW-1:BYW] = data_byte;
               comp_in = 2'd1;
            end
            2'd1: begin
               held_in[BYW-1:0] = data_byte;
               comp_in = 2'd2;
            end
            default: begin
               emit             = 1'b1;
               rsp_pixel_in     = {held_in[15:11], held_in[7:2], data_byte[7:3]};
               rsp_column_in    = pbrd_pkg::COL_W'(pix_col_in);
               rsp_row_index_in = pbrd_pkg::ROW_W'(row_in);
               rsp_row_end_in   = (EW'(pix_col_in) + EW'(1) >= row_pixels);
               comp_in          = '0;
               held_in          = '0;
               if (rsp_row_end_in) begin
                  if (FW'(row_in) + FW'(1) >= frame_rows) begin
                     row_in           = '0;
                     rsp_frame_end_in = 1'b1;
                  end else begin
                     row_in = row_in + RW'(1);
                  end
                  pix_col_in = '0;
               end else begin
                  pix_col_in = pix_col_in + CW'(1);
               end
            end
         endcase
      end

      if (literal_go) begin
         if (bytes_left_in != '0) begin
            bytes_left_in = bytes_left_in - BYW'(1);
         end
         if (bytes_left_in == '0) begin
            phase_in = pbrd_pkg::PH_HEADER;
         end
      end

      // a pixel is last if it is from a literal, the row ends, the row's bytes
      // are used up, fewer than a pixel's bytes remain, or the run pixel cap is reached
      if (cmd.take) begin
         rsp_last_in = 1'b1;
      end else begin
         rsp_last_in = rsp_row_end_in
            || (byte_col_in >= row_bytes)
            || (run_count_ff <= BYW'(pbrd_pkg::BYTES_PER_PIXEL))
            || (run_pix_ff == pbrd_pkg::RUN_PIX_W'(pbrd_pkg::MAX_RUN_PIXELS - 1));
      end

      if (cmd.step) begin
         if (run_count_ff != '0) begin
            run_count_in = run_count_ff - BYW'(1);
         end
         if (emit) begin
            run_pix_in = run_pix_ff + pbrd_pkg::RUN_PIX_W'(1);
         end
         if (run_last) begin
            phase_in      = pbrd_pkg::PH_HEADER;
            bytes_left_in = '0;
         end
      end

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= pbrd_pkg::PH_HEADER;
         bytes_left_ff <= '0;
         held_ff       <= '0;
         comp_ff       <= '0;
         byte_col_ff   <= '0;
         pix_col_ff    <= '0;
         row_ff        <= '0;
         run_count_ff  <= '0;
         run_pix_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         bytes_left_ff <= bytes_left_in;
         held_ff       <= held_in;
         comp_ff       <= comp_in;
         byte_col_ff   <= byte_col_in;
         pix_col_ff    <= pix_col_in;
         row_ff        <= row_in;
         run_count_ff  <= run_count_in;
         run_pix_ff    <= run_pix_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      run_byte_ff <= run_byte_in;
      if (emit) begin
         rsp_pixel_ff     <= rsp_pixel_in;
         rsp_column_ff    <= rsp_column_in;
         rsp_row_index_ff <= rsp_row_index_in;
         rsp_row_end_ff   <= rsp_row_end_in;
         rsp_frame_end_ff <= rsp_frame_end_in;
         rsp_last_ff      <= rsp_last_in;
      end
   end

   always_comb begin
      status.out_free    = out_free;
      status.repeat_next = !req_frame_start
         && (phase_ff != pbrd_pkg::PH_HEADER)
         && (phase_ff != pbrd_pkg::PH_LITERAL);
      status.run_last    = run_last;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel       = rsp_pixel_ff;
   assign rsp_column      = rsp_column_ff;
   assign rsp_row_index   = rsp_row_index_ff;
   assign rsp_row_end     = rsp_row_end_ff;
   assign rsp_frame_end   = rsp_frame_end_ff;
   assign rsp_last_of_run = rsp_last_ff;

endmodule

`default_nettype wire

// ===== hdl/packbits_rgb_row_decoder.sv =====
// PackBits RGB888 row decoder with RGB565 pixel output.
// Input channel (req_): one compressed byte per item, with req_frame_start
// restarting decoding at row 0, column 0 before that byte is used.
// Result channel (rsp_): one RGB565 pixel per item with its column, row and
// row/frame/run end flags. Config port (csr_): row_pixels at index 0,
// frame_rows at index 1, to be written only while the block is idle, which
// the block does not check. Timing with rsp_ free: header and literal bytes
// are taken one per cycle; a literal byte that completes a pixel shows it on
// rsp_ in the next cycle. After a repeat byte is taken, one copied byte per
// cycle (up to 129) goes through the byte unpack step, ending early once the
// row's bytes are used up or at the 43rd pixel; input is stalled meanwhile.
// Each pixel of a run leaves the cycle after the byte that completes it.
// Reset: row_pixels=320, frame_rows=240, decoding at row 0, column 0,
// waiting for a header; no result is pending.
// Receiver stall: the output register holds its pixel; no byte is taken or
// unpacked until that pixel is accepted.
`timescale 1ns / 1ps
`default_nettype none

module packbits_rgb_row_decoder #(
   parameter int MAX_ROW_PIXELS = 1024,
   parameter int MAX_FRAME_ROWS = 1024
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [pbrd_pkg::BYTE_W-1:0]          req_stream_byte,
   input  wire logic                                 req_frame_start,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic [pbrd_pkg::PIXEL_W-1:0]              rsp_pixel,
   output logic [pbrd_pkg::COL_W-1:0]                rsp_column,
   output logic [pbrd_pkg::ROW_W-1:0]                rsp_row_index,
   output logic                                      rsp_row_end,
   output logic                                      rsp_frame_end,
   output logic                                      rsp_last_of_run,
   input  wire logic                                 csr_write_enable,
   input  wire logic [pbrd_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [pbrd_pkg::CSR_W-1:0]           csr_write_data
);

   localparam int EW = $clog2(MAX_ROW_PIXELS + 1);
   localparam int FW = $clog2(MAX_FRAME_ROWS + 1);

   logic [pbrd_pkg::CSR_W-1:0] row_pixels_ff, row_pixels_in;
   logic [pbrd_pkg::CSR_W-1:0] frame_rows_ff, frame_rows_in;
   logic [EW-1:0]              eff_row_pixels;
   logic [FW-1:0]              eff_frame_rows;

   pbrd_pkg::dp_cmd_type       cmd;
   pbrd_pkg::dp_status_type    status;

   always_comb begin
      row_pixels_in = row_pixels_ff;
      frame_rows_in = frame_rows_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            pbrd_pkg::CFG_ROW_PIXELS: row_pixels_in = csr_write_data;
            pbrd_pkg::CFG_FRAME_ROWS: frame_rows_in = csr_write_data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_pixels_ff <= pbrd_pkg::ROW_PIXELS_RESET;
         frame_rows_ff <= pbrd_pkg::FRAME_ROWS_RESET;
      end else begin
         row_pixels_ff <= row_pixels_in;
         frame_rows_ff <= frame_rows_in;
      end
   end

   // zero acts as one, oversize values saturate at the maximum
   always_comb begin
      if (row_pixels_ff == '0) begin
         eff_row_pixels = EW'(1);
      end else if (32'(row_pixels_ff) > 32'(MAX_ROW_PIXELS)) begin
         eff_row_pixels = EW'(MAX_ROW_PIXELS);
      end else begin
         eff_row_pixels = EW'(row_pixels_ff);
      end
      if (frame_rows_ff == '0) begin
         eff_frame_rows = FW'(1);
      end else if (32'(frame_rows_ff) > 32'(MAX_FRAME_ROWS)) begin
         eff_frame_rows = FW'(MAX_FRAME_ROWS);
      end else begin
         eff_frame_rows = FW'(frame_rows_ff);
      end
   end

   pbrd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   pbrd_datapath #(
      .MAX_ROW_PIXELS (MAX_ROW_PIXELS),
      .MAX_FRAME_ROWS (MAX_FRAME_ROWS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .row_pixels      (eff_row_pixels),
      .frame_rows      (eff_frame_rows),
      .req_stream_byte (req_stream_byte),
      .req_frame_start (req_frame_start),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel       (rsp_pixel),
      .rsp_column      (rsp_column),
      .rsp_row_index   (rsp_row_index),
      .rsp_row_end     (rsp_row_end),
      .rsp_frame_end   (rsp_frame_end),
      .rsp_last_of_run (rsp_last_of_run)
   );

`ifndef SYNTHESIS
   frame_end_is_row_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_end |-> rsp_row_end)
      else $error("frame end without row end");

   row_end_closes_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_row_end |-> rsp_last_of_run)
      else $error("row end pixel not marked as last of its run");

   input_only_when_output_free: assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> (!rsp_valid || !rsp_stall))
      else $error("input taken while a stalled pixel is pending");
`endif

endmodule

`default_nettype wire

// ===== sim/packbits_rgb_row_decoder_test.sv =====
`timescale 1ns / 1ps

module packbits_rgb_row_decoder_test;
   import pbrd_pkg::*;

   localparam int ROW_LIMIT      = 1024;
   localparam int FRAME_LIMIT    = 1024;
   localparam int SETTLE_CYCLES  = 160;
   localparam int LONG_HOLD      = 400;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int RANDOM_PHASES  = 10;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic [COL_W-1:0]   column;
      logic [ROW_W-1:0]   row_index;
      logic               row_end;
      logic               frame_end;
      logic               last_of_run;
   } pixel_result_t;

   typedef enum logic [0:0] {
      STEP_BYTE,
      STEP_CSR
   } step_kind_t;

   typedef struct packed {
      step_kind_t             kind;
      logic [CSR_W-1:0]       value;
      logic                   frame_start;
      logic [CSR_INDEX_W-1:0] csr_sel;
      logic                   typed;
      pixel_result_t          want;
   } directed_step_t;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [BYTE_W-1:0]      req_stream_byte;
   logic                   req_frame_start;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [PIXEL_W-1:0]     rsp_pixel;
   logic [COL_W-1:0]       rsp_column;
   logic [ROW_W-1:0]       rsp_row_index;
   logic                   rsp_row_end;
   logic                   rsp_frame_end;
   logic                   rsp_last_of_run;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_W-1:0]       csr_write_data;

   packbits_rgb_row_decoder dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_stream_byte (req_stream_byte),
      .req_frame_start (req_frame_start),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel       (rsp_pixel),
      .rsp_column      (rsp_column),
      .rsp_row_index   (rsp_row_index),
      .rsp_row_end     (rsp_row_end),
      .rsp_frame_end   (rsp_frame_end),
      .rsp_last_of_run (rsp_last_of_run),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data)
   );

   // decoder mirror
   logic [CSR_W-1:0]   row_cfg;
   logic [CSR_W-1:0]   frame_cfg;
   phase_type          dec_phase;
   logic [7:0]         run_left;
   logic [15:0]        held_rg;
   logic [1:0]         comp_idx;
   logic [11:0]        byte_col;
   logic [COL_W-1:0]   pix_col;
   logic [ROW_W-1:0]   cur_row;

   pixel_result_t      pending_pixels[$];
   directed_step_t     script[$];
   pixel_result_t      drive_expect;
   pixel_result_t      got_want;
   logic               drive_typed;
   bit                 long_hold_due;
   int                 error_count;
   int                 items_sent;
   int                 directed_items;
   int                 pixels_checked;
   int                 csr_writes;
   int                 queued_before;
   int                 idle_cycles;
   int                 burst_left;

   function automatic int clamp_dim(input logic [CSR_W-1:0] v, input int limit);
      if (v == 0) return 1;
      if (int'(v) > limit) return limit;
      return int'(v);
   endfunction

   function automatic void restart_decoder();
      dec_phase = PH_HEADER;
      run_left  = '0;
      held_rg   = '0;
      comp_idx  = '0;
      byte_col  = '0;
      pix_col   = '0;
      cur_row   = '0;
   endfunction

   function automatic void next_image_row(output bit fend);
      if (int'(cur_row) + 1 >= clamp_dim(frame_cfg, FRAME_LIMIT)) begin
         cur_row = '0;
         fend    = 1'b1;
      end else begin
         cur_row++;
         fend = 1'b0;
      end
      pix_col = '0;
   endfunction

   // one data byte into the pixel assembler; returns 1 when a pixel completes
   function automatic bit take_stream_byte(input logic [7:0] b, input int rp,
                                           output pixel_result_t r);
      bit fend;
      r    = '0;
      fend = 1'b0;
      if (int'(byte_col) >= rp * BYTES_PER_PIXEL) return 1'b0;
      byte_col++;
      if (comp_idx == 2'd0) begin
         held_rg  = {b, 8'h00};
         comp_idx = 2'd1;
         return 1'b0;
      end
      if (comp_idx == 2'd1) begin
         held_rg[7:0] = b;
         comp_idx     = 2'd2;
         return 1'b0;
      end
      r.pixel     = {held_rg[15:11], held_rg[7:2], b[7:3]};
      r.column    = pix_col;
      r.row_index = cur_row;
      r.row_end   = (int'(pix_col) + 1 >= rp);
      comp_idx    = '0;
      held_rg     = '0;
      if (r.row_end) next_image_row(fend);
      else pix_col++;
      r.frame_end = fend;
      return 1'b1;
   endfunction

   task automatic decode_byte(input logic [7:0] b, input logic fs);
      int            rp;
      int            k;
      bit            fend;
      pixel_result_t r;
      pixel_result_t run[$];
      if (fs) restart_decoder();
      rp = clamp_dim(row_cfg, ROW_LIMIT);
      if (dec_phase == PH_HEADER) begin
         // a header after a finished or cut row opens the next row
         if (int'(byte_col) >= rp * BYTES_PER_PIXEL || int'(pix_col) >= rp) begin
            if (pix_col != 0) next_image_row(fend);
            byte_col = '0;
            pix_col  = '0;
            comp_idx = '0;
            held_rg  = '0;
         end
         if (b < 8'h80) begin
            dec_phase = PH_LITERAL;
            run_left  = 8'(int'(b) + 1);
         end else begin
            dec_phase = PH_REPEAT;
            run_left  = 8'(int'(REPEAT_LEN_BASE) - int'(b));
         end
      end else if (dec_phase == PH_LITERAL) begin
         if (take_stream_byte(b, rp, r)) run.push_back(r);
         if (run_left > 0) run_left--;
         if (run_left == 0) dec_phase = PH_HEADER;
      end else begin
         for (k = 0; k < int'(run_left) && run.size() < MAX_RUN_PIXELS; k++) begin
            if (take_stream_byte(b, rp, r)) run.push_back(r);
         end
         run_left  = '0;
         dec_phase = PH_HEADER;
      end
      if (run.size() > 0) run[run.size() - 1].last_of_run = 1'b1;
      foreach (run[i]) pending_pixels.push_back(run[i]);
   endtask

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         if (error_count < 40) $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
         error_count++;
      end
   endfunction

   function automatic directed_step_t data_step(input logic [7:0] b, input logic fs);
      directed_step_t s;
      s             = '0;
      s.kind        = STEP_BYTE;
      s.value       = CSR_W'(b);
      s.frame_start = fs;
      return s;
   endfunction

   function automatic directed_step_t pixel_step(input logic [7:0] b, input logic [15:0] px,
                                                 input int col, input int row,
                                                 input logic re, input logic fe);
      directed_step_t s;
      s                  = data_step(b, 1'b0);
      s.typed            = 1'b1;
      s.want.pixel       = px;
      s.want.column      = COL_W'(col);
      s.want.row_index   = ROW_W'(row);
      s.want.row_end     = re;
      s.want.frame_end   = fe;
      s.want.last_of_run = 1'b1;
      return s;
   endfunction

   function automatic directed_step_t csr_step(input logic [CSR_INDEX_W-1:0] sel,
                                               input int v);
      directed_step_t s;
      s         = '0;
      s.kind    = STEP_CSR;
      s.csr_sel = sel;
      s.value   = CSR_W'(v);
      return s;
   endfunction

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_byte(input logic [7:0] b, input logic fs,
                            input logic typed = 1'b0, input pixel_result_t want = '0);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_stream_byte = b;
      req_frame_start = fs;
      drive_typed     = typed;
      drive_expect    = want;
      req_valid       = 1'b1;
      do @(posedge clock); while (req_stall);
      items_sent++;
      @(negedge clock);
   endtask

   // sender pause: wait for every pixel, then let a repeat run finish dropping bytes
   task automatic drain_results();
      req_valid = 1'b0;
      while (pending_pixels.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] sel, input logic [CSR_W-1:0] v);
      csr_write_enable = 1'b1;
      csr_index        = sel;
      csr_write_data   = v;
      @(negedge clock);
      csr_write_enable = 1'b0;
      csr_writes++;
   endtask

   // well-formed rows with random content, plus overruns, short rows and noise
   task automatic send_rows(input int budget);
      int rp;
      int left;
      int len;
      int cap;
      int first;
      int i;
      bit big;
      first = items_sent;
      while (items_sent - first < budget) begin
         rp   = clamp_dim(row_cfg, ROW_LIMIT);
         big  = (rp * BYTES_PER_PIXEL > 48);
         cap  = big ? 8 : 128;
         left = rp * BYTES_PER_PIXEL;
         case ($urandom_range(0, 15))
            0: left = left + $urandom_range(1, 6);
            1: left = $urandom_range(1, left);
            2: send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            default: ;
         endcase
         while (left > 0) begin
            if (big ? ($urandom_range(0, 9) == 0) : ($urandom_range(0, 1) == 0)) begin
               len = $urandom_range(1, (left < cap) ? left : cap);
               send_byte(8'(len - 1), 1'($urandom_range(0, 47) == 0));
               for (i = 0; i < len; i++) send_byte(8'($urandom_range(0, 255)), 1'b0);
            end else begin
               len = big ? $urandom_range(96, 129) : $urandom_range(2, 129);
               if (len > left && $urandom_range(0, 3) != 0) len = (left < 2) ? 2 : left;
               send_byte(8'(int'(REPEAT_LEN_BASE) - len), 1'($urandom_range(0, 47) == 0));
               send_byte(8'($urandom_range(0, 255)), 1'b0);
            end
            left -= len;
         end
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // prediction and checking at the rising edge
   always @(posedge clock) begin
      if (reset) begin
         row_cfg   = ROW_PIXELS_RESET;
         frame_cfg = FRAME_ROWS_RESET;
         restart_decoder();
         pending_pixels.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CFG_ROW_PIXELS: row_cfg = csr_write_data;
               CFG_FRAME_ROWS: frame_cfg = csr_write_data;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_pixels.size() == 0) begin
               if (error_count < 40)
                  $error("unexpected pixel 'h%0h at column %0d row %0d",
                         rsp_pixel, rsp_column, rsp_row_index);
               error_count++;
            end else begin
               got_want = pending_pixels.pop_front();
               check_field("pixel", got_want.pixel, rsp_pixel);
               check_field("column", got_want.column, rsp_column);
               check_field("row_index", got_want.row_index, rsp_row_index);
               check_field("row_end", got_want.row_end, rsp_row_end);
               check_field("frame_end", got_want.frame_end, rsp_frame_end);
               check_field("last_of_run", got_want.last_of_run, rsp_last_of_run);
               pixels_checked++;
            end
         end
         if (req_valid && !req_stall) begin
            queued_before = pending_pixels.size();
            decode_byte(req_stream_byte, req_frame_start);
            if (drive_typed && pending_pixels.size() > queued_before)
               pending_pixels[pending_pixels.size() - 1] = drive_expect;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[packbits_rgb_row_decoder] ERROR");
            $finish;
         end
      end
   end

   // receiver: stall pattern changes every stretch, long hold on request
   initial begin
      int mode;
      int seg_left;
      int hold_left;
      rsp_stall = 1'b0;
      mode      = 0;
      seg_left  = 0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (long_hold_due) begin
            long_hold_due = 1'b0;
            hold_left     = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall = 1'b1;
         end else begin
            if (seg_left == 0) begin
               mode     = $urandom_range(0, 3);
               seg_left = $urandom_range(16, 96);
            end
            seg_left--;
            case (mode)
               0: rsp_stall = 1'b0;
               1: rsp_stall = ($urandom_range(0, 3) == 0);
               2: rsp_stall = 1'($urandom_range(0, 1));
               default: rsp_stall = ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   initial begin
      int p;
      int row_set;
      int frame_set;
      int budget;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_stream_byte  = '0;
      req_frame_start  = 1'b0;
      csr_write_enable = 1'b0;
      csr_index        = '0;
      csr_write_data   = '0;
      drive_typed      = 1'b0;
      drive_expect     = '0;
      long_hold_due    = 1'b0;
      error_count      = 0;
      items_sent       = 0;
      pixels_checked   = 0;
      csr_writes       = 0;
      idle_cycles      = 0;
      burst_left       = 0;

      // first pixel under reset settings, then a full 129-copy run
      script.push_back(data_step(8'h02, 1'b1));
      script.push_back(data_step(8'hFF, 1'b0));
      script.push_back(data_step(8'hFF, 1'b0));
      script.push_back(pixel_step(8'hFF, 16'hFFFF, 0, 0, 1'b0, 1'b0));
      script.push_back(data_step(8'h80, 1'b0));
      script.push_back(data_step(8'h00, 1'b0));
      // shrink the row mid-row: next header cuts it and moves to row 1
      script.push_back(csr_step(CFG_ROW_PIXELS, 2));
      script.push_back(csr_step(CFG_FRAME_ROWS, 2));
      script.push_back(data_step(8'h05, 1'b0));
      script.push_back(data_step(8'hF8, 1'b0));
      script.push_back(data_step(8'h03, 1'b0));
      script.push_back(pixel_step(8'h07, 16'hF800, 0, 1, 1'b0, 1'b0));
      script.push_back(data_step(8'h07, 1'b0));
      script.push_back(data_step(8'hFC, 1'b0));
      script.push_back(pixel_step(8'h1F, 16'h07E3, 1, 1, 1'b1, 1'b1));
      // pixel split across a literal and a short repeat, then a repeat overrunning the row
      script.push_back(data_step(8'h00, 1'b0));
      script.push_back(data_step(8'h12, 1'b0));
      script.push_back(data_step(8'hFF, 1'b0));
      script.push_back(data_step(8'hAB, 1'b0));
      script.push_back(data_step(8'h81, 1'b0));
      script.push_back(data_step(8'h55, 1'b0));
      // frame restart on a header and in the middle of a literal
      script.push_back(data_step(8'h7F, 1'b1));
      script.push_back(data_step(8'h00, 1'b0));
      script.push_back(data_step(8'h00, 1'b0));
      script.push_back(pixel_step(8'h00, 16'h0000, 0, 0, 1'b0, 1'b0));
      script.push_back(data_step(8'h80, 1'b1));
      script.push_back(data_step(8'hFF, 1'b0));

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (script[i]) begin
         if (script[i].kind == STEP_CSR) begin
            drain_results();
            write_csr(script[i].csr_sel, script[i].value);
         end else begin
            send_byte(script[i].value[7:0], script[i].frame_start, script[i].typed,
                      script[i].want);
         end
      end
      directed_items = items_sent;

      for (p = 0; p < RANDOM_PHASES; p++) begin
         budget = 40;
         case (p)
            0: begin row_set = 2;    frame_set = 2;    end
            1: begin row_set = 1;    frame_set = 1;    end
            2: begin row_set = 0;    frame_set = 0;    end
            3: begin row_set = 6;    frame_set = 1024; end
            4: begin row_set = 2047; frame_set = 2047; budget = 60; end
            5: begin row_set = 1024; frame_set = 1;    budget = 60; end
            default: begin
               row_set   = $urandom_range(1, 8);
               frame_set = $urandom_range(1, 6);
            end
         endcase
         drain_results();
         write_csr(CFG_ROW_PIXELS, CSR_W'(row_set));
         write_csr(CFG_FRAME_ROWS, CSR_W'(frame_set));
         // receiver holds off while the sender keeps offering bytes
         if (p == 3) long_hold_due = 1'b1;
         send_rows(budget);
      end

      drain_results();
      $display("run covered %0d compressed bytes (%0d directed) and %0d checked pixels",
               items_sent, directed_items, pixels_checked);
      $display("over %0d register writes, row sizes 0 to 2047 and frame sizes 0 to 2047",
               csr_writes);
      if (error_count == 0) begin
         $display("[packbits_rgb_row_decoder] OK");
      end else begin
         $display("[packbits_rgb_row_decoder] ERROR");
      end
      $finish;
   end

endmodule
